// ===== design/dar_pkg.sv =====
package dar_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned MAX_CHARS = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PAIR_W    = 7;   // holds 0..99
  localparam int unsigned LOW_W     = 14;  // holds 0..9999

  localparam logic [VALUE_W-1:0] MAX_SHOWN   = 16'd9999;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0]  ASCII_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0]  ASCII_DASH  = 8'h2D;

  localparam logic FUNC_VOLT = 1'b0;
  localparam logic FUNC_FREQ = 1'b1;

  typedef logic [2:0]                         count_t;
  typedef logic [CHAR_W-1:0]                  char_t;
  typedef logic [MAX_CHARS-1:0][CHAR_W-1:0]   line_t;

  localparam count_t VOLT_COUNT = 3'd5;
  localparam count_t FREQ_COUNT = 3'd4;

  // reading split into two base-100 places
  typedef struct packed {
    logic [PAIR_W-1:0] hi;   // thousands and hundreds
    logic [PAIR_W-1:0] lo;   // tens and units
    logic              func;
    logic              bad;  // invalid marker or more than four digits
  } split_t;

  // x / 10 for x below 100, reciprocal multiply
  function automatic logic [DIGIT_W-1:0] div10(input logic [PAIR_W-1:0] x);
    logic [PAIR_W+7:0] prod;
    prod = {8'd0, x} * 15'd205;
    return prod[14:11];
  endfunction

  // x % 10 given its quotient
  function automatic logic [DIGIT_W-1:0] mod10(input logic [PAIR_W-1:0] x,
                                               input logic [DIGIT_W-1:0] q);
    logic [PAIR_W-1:0] rem;
    rem = x - PAIR_W'({3'd0, q} * 7'd10);
    return rem[DIGIT_W-1:0];
  endfunction

  function automatic char_t digit_char(input logic [DIGIT_W-1:0] d);
    return ASCII_ZERO + {4'd0, d};
  endfunction

endpackage

// ===== design/dar_in_if.sv =====
interface dar_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        func;

  modport source (output valid, output value, output func, input ready);
  modport sink   (input valid, input value, input func, output ready);
endinterface

// ===== design/dar_out_if.sv =====
interface dar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/decimal_ascii_readout_formatter_top.sv =====
// Formats a 16-bit reading as ASCII, leftmost character first, one character
// per output item with last set on the final one. func 0 gives five characters
// d.ddd (reading in millivolts); func 1 gives four characters with leading
// zeros blanked to spaces, units digit always shown. Readings above 9999,
// including the invalid marker 0xFFFF, give dashes (five or four). An accepted
// reading is registered in the input register and then loaded into the
// character output register, which sends one character per cycle while readout
// is ready; the next reading is taken and converted while the current
// characters drain.
module decimal_ascii_readout_formatter_top (
  input logic       clk,
  input logic       rst,
  dar_in_if.sink    reading,
  dar_out_if.source readout
);
  import dar_pkg::*;

  split_t split;
  logic   split_valid;
  logic   load_ready;
  line_t  line;
  count_t count;

  // input register: reading split into two base-100 places
  dar_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (reading.valid),
    .in_ready    (reading.ready),
    .value       (reading.value),
    .func        (reading.func),
    .advance     (split_valid && load_ready),
    .split_valid (split_valid),
    .split       (split)
  );

  // digits, blanking and dash substitution
  dar_format u_format (
    .split (split),
    .line  (line),
    .count (count)
  );

  // character output register, shifts one character out per item
  dar_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load_valid (split_valid),
    .load_ready (load_ready),
    .load_line  (line),
    .load_count (count),
    .out_valid  (readout.valid),
    .out_ready  (readout.ready),
    .character  (readout.character),
    .last       (readout.last)
  );

endmodule

// ===== design/dar_front.sv =====
module dar_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dar_pkg::VALUE_W-1:0]    value,
  input  logic                           func,
  input  logic                           advance,
  output logic                           split_valid,
  output dar_pkg::split_t                split
);
  import dar_pkg::*;

  logic [LOW_W-1:0]   low_bits;
  logic [LOW_W+12:0]  prod;
  logic [PAIR_W-1:0]  hi_next;
  logic [LOW_W-1:0]   lo_full;
  split_t             split_next;

  // value / 100 by reciprocal 5243 / 2^19, exact below 10000
  always_comb begin
    low_bits          = value[LOW_W-1:0];
    prod              = {13'd0, low_bits} * 27'd5243;
    hi_next           = prod[25:19];
    lo_full           = low_bits - LOW_W'({7'd0, hi_next} * 14'd100);
    split_next.hi     = hi_next;
    split_next.lo     = lo_full[PAIR_W-1:0];
    split_next.func   = func;
    split_next.bad    = (value > MAX_SHOWN);
  end

  assign in_ready = !split_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      split_valid <= 1'b1;
    end else if (advance) begin
      split_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      split <= split_next;
    end
  end

endmodule

// ===== design/dar_format.sv =====
module dar_format (
  input  dar_pkg::split_t  split,
  output dar_pkg::line_t   line,
  output dar_pkg::count_t  count
);
  import dar_pkg::*;

  logic [DIGIT_W-1:0] d0, d1, d2, d3;

  always_comb begin
    d0 = div10(split.hi);
    d1 = mod10(split.hi, d0);
    d2 = div10(split.lo);
    d3 = mod10(split.lo, d2);
    line = '0;
    if (split.func == FUNC_FREQ) begin
      count = FREQ_COUNT;
    end else begin
      count = VOLT_COUNT;
    end
    if (split.bad) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        line[i] = ASCII_DASH;
      end
    end else if (split.func == FUNC_FREQ) begin
      // leading zero places blank, units always shown
      line[0] = (split.hi < 7'd10) ? ASCII_SPACE : digit_char(d0);
      line[1] = (split.hi == '0) ? ASCII_SPACE : digit_char(d1);
      line[2] = (split.hi == '0 && split.lo < 7'd10) ? ASCII_SPACE : digit_char(d2);
      line[3] = digit_char(d3);
    end else begin
      line[0] = digit_char(d0);
      line[1] = ASCII_DOT;
      line[2] = digit_char(d1);
      line[3] = digit_char(d2);
      line[4] = digit_char(d3);
    end
  end

endmodule

// ===== design/dar_serial.sv =====
module dar_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_valid,
  output logic                  load_ready,
  input  dar_pkg::line_t        load_line,
  input  dar_pkg::count_t       load_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dar_pkg::char_t        character,
  output logic                  last
);
  import dar_pkg::*;

  line_t  line;
  count_t left;

  assign last       = (left == 3'd1);
  assign character  = line[0];
  assign load_ready = !out_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= '0;
    end else if (load_valid && load_ready) begin
      out_valid <= 1'b1;
      left      <= load_count;
    end else if (out_valid && out_ready) begin
      left <= left - 3'd1;
      if (last) begin
        out_valid <= 1'b0;
      end
    end
    if (load_valid && load_ready) begin
      line <= load_line;
    end else if (out_valid && out_ready) begin
      line <= {ASCII_SPACE, line[MAX_CHARS-1:1]};
    end
  end

endmodule
